>>> design/kaf_pkg.sv
// kaf_pkg: shared types, constants and saturation helpers for the kalman angle fusion block
// no dependencies
`timescale 1ns / 1ps

package kaf_pkg;

   // field and state widths
   localparam int MEAS_W   = 24;
   localparam int GYRO_W   = 28;
   localparam int FUSED_W  = 25;
   localparam int RATE_W   = 28;
   localparam int EST_W    = 32;
   localparam int COV_W    = 48;
   localparam int CSR_W    = 44;
   localparam int CSR_IDX_W = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP     = 2'd3;

   // register reset values
   localparam logic [40:0] ANGLE_NOISE_RST   = 41'd219902326;
   localparam logic [40:0] BIAS_NOISE_RST    = 41'd1099512;
   localparam logic [43:0] MEASURE_NOISE_RST = 44'd549755813888;
   localparam logic [31:0] TIME_STEP_RST     = 32'd21474836;

   localparam logic signed [COV_W-1:0] ONE_Q40  = 48'sh0100_0000_0000;
   localparam logic [47:0]             GAIN_MAX = 48'h7FFF_FFFF_FFFF;

   // output limits
   localparam logic signed [EST_W:0] FUSED_MAX = 33'sd11796480;
   localparam logic signed [EST_W:0] FUSED_MIN = -33'sd11796480;
   localparam logic signed [EST_W:0] RATE_MAX  = 33'sd131072000;
   localparam logic signed [EST_W:0] RATE_MIN  = -33'sd131072000;

   localparam logic signed [64:0] MAX32 = 65'sd2147483647;
   localparam logic signed [64:0] MIN32 = -65'sd2147483648;
   localparam logic signed [64:0] MAX48 = 65'sd140737488355327;
   localparam logic signed [64:0] MIN48 = -65'sd140737488355328;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_ANGLE,
      OP_AA,
      OP_AB,
      OP_BB,
      OP_K0,
      OP_K1,
      OP_PAA,
      OP_PAB,
      OP_PBA,
      OP_PBB,
      OP_ANG2,
      OP_BIAS
   } op_type;

   function automatic logic signed [EST_W-1:0] sat32(input logic signed [64:0] v);
      logic signed [EST_W-1:0] r;
      if (v > MAX32) r = MAX32[EST_W-1:0];
      else if (v < MIN32) r = MIN32[EST_W-1:0];
      else r = v[EST_W-1:0];
      return r;
   endfunction

   function automatic logic signed [COV_W-1:0] sat48(input logic signed [64:0] v);
      logic signed [COV_W-1:0] r;
      if (v > MAX48) r = MAX48[COV_W-1:0];
      else if (v < MIN48) r = MIN48[COV_W-1:0];
      else r = v[COV_W-1:0];
      return r;
   endfunction

endpackage

>>> design/kaf_mul.sv
// kaf_mul: bit-serial signed multiplier, round(a*b/2^32) with magnitude limit 2^62
// depends on kaf_pkg
`timescale 1ns / 1ps

module kaf_mul
   import kaf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] a_in,
   input  logic signed [48:0] b_in,
   output logic               done,
   output logic signed [63:0] result
);

   logic [63:0]  a_mag_ff;
   logic [47:0]  b_mag_ff;
   logic [111:0] acc_ff;
   logic         neg_ff;
   logic [5:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;

   logic [63:0]  a_abs;
   logic [48:0]  b_abs;
   logic [64:0]  sum;
   logic [112:0] rnd;
   logic [80:0]  mag_r;
   logic [63:0]  mag_s;

   assign a_abs = a_in[63] ? (64'd0 - a_in) : a_in;
   assign b_abs = b_in[48] ? (49'd0 - b_in) : b_in;

   // one multiplier bit per cycle into the upper 64 bits of the accumulator
   assign sum = {1'b0, acc_ff[111:48]} + (b_mag_ff[0] ? {1'b0, a_mag_ff} : 65'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd48;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_mag_ff <= a_abs;
         b_mag_ff <= b_abs[47:0];
         acc_ff   <= 112'd0;
         neg_ff   <= a_in[63] ^ b_in[48];
      end else if (busy_ff) begin
         acc_ff   <= {sum, acc_ff[47:1]};
         b_mag_ff <= {1'b0, b_mag_ff[47:1]};
      end
   end

   // round half away from zero, then limit to 2^62
   assign rnd   = {1'b0, acc_ff} + 113'h8000_0000;
   assign mag_r = rnd[112:32];
   assign mag_s = (mag_r > 81'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : mag_r[63:0];

   assign result = neg_ff ? (64'd0 - mag_s) : mag_s;
   assign done   = done_ff;

endmodule

>>> design/kaf_div.sv
// kaf_div: restoring bit-serial divider, round(num*2^32/den) saturated to the gain limit
// depends on kaf_pkg
`timescale 1ns / 1ps

module kaf_div
   import kaf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] num_in,
   input  logic [47:0]        den_in,
   output logic               done,
   output logic signed [47:0] quot
);

   logic [47:0] rem_ff;
   logic [47:0] nb_ff;
   logic [47:0] q_ff;
   logic [47:0] den_ff;
   logic        neg_ff;
   logic        ovf_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [47:0] un;
   logic        ovf;
   logic [48:0] trial;
   logic        ge;
   logic [48:0] diff;
   logic        rup;
   logic [48:0] res;
   logic [47:0] res_c;

   assign un  = num_in[47] ? (48'd0 - num_in) : num_in;
   // integer quotient of 2^15 or more always saturates
   assign ovf = {15'd0, un} >= {den_in, 15'd0};

   assign trial = {rem_ff, nb_ff[47]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= !ovf;
            done_ff <= ovf;
            cnt_ff  <= 6'd48;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {16'd0, un[47:16]};
         nb_ff  <= {un[15:0], 32'd0};
         q_ff   <= 48'd0;
         den_ff <= den_in;
         neg_ff <= num_in[47];
         ovf_ff <= ovf;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[47:0] : trial[47:0];
         nb_ff  <= {nb_ff[46:0], 1'b0};
         q_ff   <= {q_ff[46:0], ge};
      end
   end

   // round on the remainder, then limit
   assign rup   = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign res   = {1'b0, q_ff} + {48'd0, rup};
   assign res_c = (ovf_ff || res > {1'b0, GAIN_MAX}) ? GAIN_MAX : res[47:0];

   assign quot = neg_ff ? (48'd0 - res_c) : res_c;
   assign done = done_ff;

endmodule

>>> design/kalman_angle_fusion.sv
// kalman_angle_fusion: two-state angle and gyro bias estimator, top level and sequencer
// depends on kaf_pkg, kaf_mul, kaf_div
// sequencing: the multiplies and gain divides run one after another on the shared serial units;
//   the correction steps are skipped when the innovation variance is not positive, and a divide
//   whose gain saturates ends without its serial steps
// handshake: one item at a time, next taken the cycle after the result is loaded
// reset: synchronous, restores registers to defaults, estimates to zero, diagonal covariance one
`timescale 1ns / 1ps

module kalman_angle_fusion
   import kaf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [MEAS_W-1:0]    req_measured_angle,
   input  logic signed [GYRO_W-1:0]    req_gyro_rate,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [FUSED_W-1:0]   rsp_fused_angle,
   output logic signed [RATE_W-1:0]    rsp_corrected_rate,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [40:0] angle_noise_ff;
   logic [40:0] bias_noise_ff;
   logic [43:0] measure_noise_ff;
   logic [31:0] time_step_ff;

   logic signed [EST_W-1:0] angle_ff, angle_in;
   logic signed [EST_W-1:0] bias_ff, bias_in;
   logic signed [COV_W-1:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [COV_W-1:0] k0_ff, k0_in, k1_ff, k1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic signed [EST_W:0]   err_ff, err_in;
   logic signed [MEAS_W-1:0] meas_ff;
   logic signed [GYRO_W-1:0] gyro_ff;

   logic                      rsp_valid_ff;
   logic signed [FUSED_W-1:0] fused_ff;
   logic signed [RATE_W-1:0]  rate_out_ff;

   logic               mul_start, mul_done;
   logic signed [63:0] mul_a;
   logic signed [48:0] mul_b;
   logic signed [63:0] mul_p;
   logic               div_start, div_done;
   logic signed [47:0] div_num;
   logic signed [47:0] div_q;

   logic               is_div, op_done, out_load;
   logic signed [48:0] e_sum;
   logic               e_pos;
   logic signed [EST_W:0] rate_now;
   logic signed [49:0] d_aa;
   logic signed [64:0] p_ext;
   logic signed [EST_W-1:0] fused_sat;
   logic signed [RATE_W-1:0] rate_sat;

   kaf_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a_in   (mul_a),
      .b_in   (mul_b),
      .done   (mul_done),
      .result (mul_p)
   );

   kaf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_in (div_num),
      .den_in (e_sum[47:0]),
      .done   (div_done),
      .quot   (div_q)
   );

   // shared terms
   assign rate_now = {{(EST_W+1-GYRO_W){gyro_ff[GYRO_W-1]}}, gyro_ff} - {bias_ff[EST_W-1], bias_ff};
   assign d_aa     = {9'd0, angle_noise_ff} - {{2{ab_ff[COV_W-1]}}, ab_ff}
                     - {{2{ba_ff[COV_W-1]}}, ba_ff};
   assign e_sum    = {5'd0, measure_noise_ff} + {aa_ff[COV_W-1], aa_ff};
   assign e_pos    = !e_sum[48] && (e_sum != 49'sd0);
   assign p_ext    = {mul_p[63], mul_p};

   assign is_div    = (op_ff == OP_K0) || (op_ff == OP_K1);
   assign mul_start = (state_ff == ST_ISSUE) && !is_div;
   assign div_start = (state_ff == ST_ISSUE) && is_div;
   assign op_done   = is_div ? div_done : mul_done;
   assign div_num   = (op_ff == OP_K0) ? aa_ff : ba_ff;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // multiplier operands per step
   always_comb begin
      mul_a = 64'sd0;
      mul_b = 49'sd0;
      case (op_ff)
         OP_ANGLE: begin
            mul_a = {{(64-EST_W-1){rate_now[EST_W]}}, rate_now};
            mul_b = {17'd0, time_step_ff};
         end
         OP_AA: begin
            mul_a = {{14{d_aa[49]}}, d_aa};
            mul_b = {17'd0, time_step_ff};
         end
         OP_AB: begin
            mul_a = 64'sd0 - {{16{bb_ff[COV_W-1]}}, bb_ff};
            mul_b = {17'd0, time_step_ff};
         end
         OP_BB: begin
            mul_a = {23'd0, bias_noise_ff};
            mul_b = {17'd0, time_step_ff};
         end
         OP_PAA: begin
            mul_a = {{16{k0_ff[COV_W-1]}}, k0_ff};
            mul_b = {t0_ff[COV_W-1], t0_ff};
         end
         OP_PAB: begin
            mul_a = {{16{k0_ff[COV_W-1]}}, k0_ff};
            mul_b = {t1_ff[COV_W-1], t1_ff};
         end
         OP_PBA: begin
            mul_a = {{16{k1_ff[COV_W-1]}}, k1_ff};
            mul_b = {t0_ff[COV_W-1], t0_ff};
         end
         OP_PBB: begin
            mul_a = {{16{k1_ff[COV_W-1]}}, k1_ff};
            mul_b = {t1_ff[COV_W-1], t1_ff};
         end
         OP_ANG2: begin
            mul_a = {{16{k0_ff[COV_W-1]}}, k0_ff};
            mul_b = {{(49-EST_W-1){err_ff[EST_W]}}, err_ff};
         end
         OP_BIAS: begin
            mul_a = {{16{k1_ff[COV_W-1]}}, k1_ff};
            mul_b = {{(49-EST_W-1){err_ff[EST_W]}}, err_ff};
         end
         default: begin
            mul_a = 64'sd0;
            mul_b = 49'sd0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
               op_in    = OP_ANGLE;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (op_done) begin
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_ANGLE: op_in = OP_AA;
                  OP_AA:    op_in = OP_AB;
                  OP_AB:    op_in = OP_BB;
                  OP_BB: begin
                     if (e_pos) op_in = OP_K0;
                     else state_in = ST_OUT;
                  end
                  OP_K0:    op_in = OP_K1;
                  OP_K1:    op_in = OP_PAA;
                  OP_PAA:   op_in = OP_PAB;
                  OP_PAB:   op_in = OP_PBA;
                  OP_PBA:   op_in = OP_PBB;
                  OP_PBB:   op_in = OP_ANG2;
                  OP_ANG2:  op_in = OP_BIAS;
                  OP_BIAS:  state_in = ST_OUT;
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_OUT: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ANGLE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // state write-back when a step finishes
   always_comb begin
      angle_in = angle_ff;
      bias_in  = bias_ff;
      aa_in    = aa_ff;
      ab_in    = ab_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      err_in   = err_ff;
      if (state_ff == ST_WAIT && op_done) begin
         case (op_ff)
            OP_ANGLE: angle_in = sat32({{33{angle_ff[EST_W-1]}}, angle_ff} + p_ext);
            OP_AA:    aa_in = sat48({{17{aa_ff[COV_W-1]}}, aa_ff} + p_ext);
            OP_AB: begin
               ab_in = sat48({{17{ab_ff[COV_W-1]}}, ab_ff} + p_ext);
               ba_in = sat48({{17{ba_ff[COV_W-1]}}, ba_ff} + p_ext);
            end
            OP_BB: begin
               bb_in  = sat48({{17{bb_ff[COV_W-1]}}, bb_ff} + p_ext);
               t0_in  = aa_ff;
               t1_in  = ab_ff;
               err_in = {{(EST_W+1-MEAS_W){meas_ff[MEAS_W-1]}}, meas_ff}
                        - {angle_ff[EST_W-1], angle_ff};
            end
            OP_K0:    k0_in = div_q;
            OP_K1:    k1_in = div_q;
            OP_PAA:   aa_in = sat48({{17{aa_ff[COV_W-1]}}, aa_ff} - p_ext);
            OP_PAB:   ab_in = sat48({{17{ab_ff[COV_W-1]}}, ab_ff} - p_ext);
            OP_PBA:   ba_in = sat48({{17{ba_ff[COV_W-1]}}, ba_ff} - p_ext);
            OP_PBB:   bb_in = sat48({{17{bb_ff[COV_W-1]}}, bb_ff} - p_ext);
            OP_ANG2:  angle_in = sat32({{33{angle_ff[EST_W-1]}}, angle_ff} + p_ext);
            OP_BIAS:  bias_in = sat32({{33{bias_ff[EST_W-1]}}, bias_ff} + p_ext);
            default:  angle_in = angle_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         bias_ff  <= '0;
         aa_ff    <= ONE_Q40;
         ab_ff    <= '0;
         ba_ff    <= '0;
         bb_ff    <= ONE_Q40;
      end else begin
         angle_ff <= angle_in;
         bias_ff  <= bias_in;
         aa_ff    <= aa_in;
         ab_ff    <= ab_in;
         ba_ff    <= ba_in;
         bb_ff    <= bb_in;
      end
   end

   always_ff @(posedge clock) begin
      k0_ff  <= k0_in;
      k1_ff  <= k1_in;
      t0_ff  <= t0_in;
      t1_ff  <= t1_in;
      err_ff <= err_in;
      if (state_ff == ST_IDLE && req_valid) begin
         meas_ff <= req_measured_angle;
         gyro_ff <= req_gyro_rate;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_noise_ff   <= ANGLE_NOISE_RST;
         bias_noise_ff    <= BIAS_NOISE_RST;
         measure_noise_ff <= MEASURE_NOISE_RST;
         time_step_ff     <= TIME_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ANGLE_NOISE:   angle_noise_ff   <= csr_wdata[40:0];
            CSR_BIAS_NOISE:    bias_noise_ff    <= csr_wdata[40:0];
            CSR_MEASURE_NOISE: measure_noise_ff <= csr_wdata[43:0];
            CSR_TIME_STEP:     time_step_ff     <= csr_wdata[31:0];
            default:           time_step_ff     <= time_step_ff;
         endcase
      end
   end

   // output limits
   always_comb begin
      if ($signed({angle_ff[EST_W-1], angle_ff}) > FUSED_MAX)
         fused_sat = FUSED_MAX[EST_W-1:0];
      else if ($signed({angle_ff[EST_W-1], angle_ff}) < FUSED_MIN)
         fused_sat = FUSED_MIN[EST_W-1:0];
      else fused_sat = angle_ff;
      if (rate_now > RATE_MAX) rate_sat = RATE_MAX[RATE_W-1:0];
      else if (rate_now < RATE_MIN) rate_sat = RATE_MIN[RATE_W-1:0];
      else rate_sat = rate_now[RATE_W-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         fused_ff    <= fused_sat[FUSED_W-1:0];
         rate_out_ff <= rate_sat;
      end
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fused_angle    = fused_ff;
   assign rsp_corrected_rate = rate_out_ff;

endmodule
